[src/sliding_window_maximum_macros.svh]
// Assertion helpers used by the checker of this block.
`ifndef SLIDING_WINDOW_MAXIMUM_MACROS_SVH
`define SLIDING_WINDOW_MAXIMUM_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define SWM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sliding_window_maximum check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define SWM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sliding_window_maximum check failed");

`endif

[src/swm_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package swm_pkg;

    localparam int WINDOW_MAX = 64;
    localparam int QIDX_W     = $clog2(WINDOW_MAX);
    localparam int CNT_W      = QIDX_W + 1;
    localparam int POS_W      = $clog2(4 * WINDOW_MAX);
    localparam int SAMPLE_W   = 32;
    localparam int CFG_W      = 7;
    localparam int ENTRY_W    = SAMPLE_W + POS_W;

    typedef struct packed {
        logic load;        // take a sample transfer
        logic rd_head;     // read queue head entry
        logic rd_tail;     // read queue tail entry
        logic pop_head;    // head entry expired
        logic keep_front;  // head entry survives, hold its value
        logic pop_tail;    // tail entry smaller than sample
        logic append;      // write sample, update counters
        logic emit;        // load output register
    } swm_cmd_t;

    typedef struct packed {
        logic count_zero;
        logic expired;
        logic smaller;
        logic produce;
        logic out_free;
    } swm_status_t;

endpackage

`default_nettype wire

[src/swm_ctrl.sv]
`timescale 1ns / 1ps
`default_nettype none

module swm_ctrl (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire swm_pkg::swm_status_t status,
    output swm_pkg::swm_cmd_t        cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_HEAD_RD,
        ST_HEAD_CHK,
        ST_TAIL_RD,
        ST_TAIL_CHK,
        ST_APPEND,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid)
                begin
                    state_next = ST_HEAD_RD;
                end
            end
            ST_HEAD_RD:
            begin
                cmd.rd_head = !status.count_zero;
                state_next  = status.count_zero ? ST_APPEND : ST_HEAD_CHK;
            end
            ST_HEAD_CHK:
            begin
                if (status.expired)
                begin
                    cmd.pop_head = 1'b1;
                    state_next   = ST_HEAD_RD;
                end
                else
                begin
                    cmd.keep_front = 1'b1;
                    state_next     = ST_TAIL_RD;
                end
            end
            ST_TAIL_RD:
            begin
                cmd.rd_tail = !status.count_zero;
                state_next  = status.count_zero ? ST_APPEND : ST_TAIL_CHK;
            end
            ST_TAIL_CHK:
            begin
                if (status.smaller)
                begin
                    cmd.pop_tail = 1'b1;
                    state_next   = ST_TAIL_RD;
                end
                else
                begin
                    state_next = ST_APPEND;
                end
            end
            ST_APPEND:
            begin
                cmd.append = 1'b1;
                state_next = status.produce ? ST_EMIT : ST_IDLE;
            end
            ST_EMIT:
            begin
                cmd.emit = status.out_free;
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

`default_nettype wire

[src/swm_datapath.sv]
`timescale 1ns / 1ps
`default_nettype none

module swm_datapath (
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire swm_pkg::swm_cmd_t                cmd,
    output swm_pkg::swm_status_t                  status,
    input  wire logic [swm_pkg::SAMPLE_W-1:0]     in_sample,
    input  wire logic                             in_last,
    input  wire logic                             cfg_valid,
    input  wire logic [swm_pkg::CFG_W-1:0]        cfg_data,
    output logic                                  out_valid,
    input  wire logic                             out_ready,
    output logic [swm_pkg::SAMPLE_W-1:0]          out_max,
    output logic                                  out_last
);

    logic [swm_pkg::ENTRY_W-1:0]  queue_mem [swm_pkg::WINDOW_MAX];
    logic [swm_pkg::ENTRY_W-1:0]  rd_data_reg;

    logic [swm_pkg::CFG_W-1:0]    ws_reg;
    logic [swm_pkg::QIDX_W-1:0]   head_reg;
    logic [swm_pkg::CNT_W-1:0]    count_reg;
    logic [swm_pkg::POS_W-1:0]    pos_reg;
    logic [swm_pkg::CNT_W-1:0]    seen_reg;
    logic                         out_valid_reg;

    logic [swm_pkg::SAMPLE_W-1:0] sample_reg;
    logic                         last_reg;
    logic [swm_pkg::CNT_W-1:0]    win_reg;
    logic [swm_pkg::SAMPLE_W-1:0] front_reg;
    logic [swm_pkg::SAMPLE_W-1:0] out_max_reg;
    logic                         out_last_reg;

    logic [swm_pkg::CNT_W-1:0]    win_next;
    logic [swm_pkg::CNT_W-1:0]    seen_next;
    logic [swm_pkg::SAMPLE_W-1:0] front_next;
    logic [swm_pkg::QIDX_W-1:0]   tail_addr;
    logic [swm_pkg::QIDX_W-1:0]   wr_addr;
    logic [swm_pkg::QIDX_W-1:0]   rd_addr;
    logic [swm_pkg::SAMPLE_W-1:0] rd_value;
    logic [swm_pkg::POS_W-1:0]    rd_pos;
    logic [swm_pkg::POS_W-1:0]    age;
    logic                         produce;

    always_comb
    begin
        if (ws_reg == '0)
        begin
            win_next = swm_pkg::CNT_W'(1);
        end
        else if (ws_reg > swm_pkg::CFG_W'(swm_pkg::WINDOW_MAX))
        begin
            win_next = swm_pkg::CNT_W'(swm_pkg::WINDOW_MAX);
        end
        else
        begin
            win_next = swm_pkg::CNT_W'(ws_reg);
        end
    end

    assign tail_addr  = head_reg + count_reg[swm_pkg::QIDX_W-1:0] - swm_pkg::QIDX_W'(1);
    assign wr_addr    = head_reg + count_reg[swm_pkg::QIDX_W-1:0];
    assign rd_addr    = cmd.rd_tail ? tail_addr : head_reg;
    assign rd_value   = rd_data_reg[swm_pkg::ENTRY_W-1:swm_pkg::POS_W];
    assign rd_pos     = rd_data_reg[swm_pkg::POS_W-1:0];
    assign age        = pos_reg - rd_pos;
    assign seen_next  = (seen_reg >= win_reg) ? win_reg : seen_reg + swm_pkg::CNT_W'(1);
    assign produce    = (seen_next == win_reg);
    assign front_next = (count_reg == '0) ? sample_reg : front_reg;

    assign status.count_zero = (count_reg == '0);
    assign status.expired    = (age >= swm_pkg::POS_W'(win_reg));
    assign status.smaller    = ($signed(rd_value) < $signed(sample_reg));
    assign status.produce    = produce;
    assign status.out_free   = !out_valid_reg || out_ready;

    assign out_valid = out_valid_reg;
    assign out_max   = out_max_reg;
    assign out_last  = out_last_reg;

    // queue storage, one write and one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.append)
        begin
            queue_mem[wr_addr] <= {sample_reg, pos_reg};
        end
        if (cmd.rd_head || cmd.rd_tail)
        begin
            rd_data_reg <= queue_mem[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ws_reg        <= swm_pkg::CFG_W'(1);
            head_reg      <= '0;
            count_reg     <= '0;
            pos_reg       <= '0;
            seen_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                ws_reg <= cfg_data;
            end

            if (cmd.pop_head)
            begin
                head_reg  <= head_reg + swm_pkg::QIDX_W'(1);
                count_reg <= count_reg - swm_pkg::CNT_W'(1);
            end
            else if (cmd.pop_tail)
            begin
                count_reg <= count_reg - swm_pkg::CNT_W'(1);
            end
            else if (cmd.append)
            begin
                if (last_reg && !produce)
                begin
                    head_reg  <= '0;
                    count_reg <= '0;
                    pos_reg   <= '0;
                    seen_reg  <= '0;
                end
                else
                begin
                    count_reg <= count_reg + swm_pkg::CNT_W'(1);
                    pos_reg   <= pos_reg + swm_pkg::POS_W'(1);
                    seen_reg  <= seen_next;
                end
            end
            else if (cmd.emit && last_reg)
            begin
                head_reg  <= '0;
                count_reg <= '0;
                pos_reg   <= '0;
                seen_reg  <= '0;
            end

            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            sample_reg <= in_sample;
            last_reg   <= in_last;
            win_reg    <= win_next;
        end
        if (cmd.keep_front)
        begin
            front_reg <= rd_value;
        end
        else if (cmd.append)
        begin
            front_reg <= front_next;
        end
        if (cmd.emit)
        begin
            out_max_reg  <= front_reg;
            out_last_reg <= last_reg;
        end
    end

endmodule

`default_nettype wire

[src/sliding_window_maximum.sv]
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Data                                   Marker
// s_axis    in   tdata[31:0] sample (signed)            tlast end_of_run
// m_axis    out  tdata[31:0] window_max (signed)        tlast last_result
// cfg       in   cfg_data[6:0] window_size              -
//
// One sample at a time: the head entries are read and checked one by one until one survives,
// then the tail entries until one is not smaller, each read through the single read port of
// the queue memory; then the sample is appended and, if a result is due, emitted.
// Reset clears the counters and sets window_size to 1; the queue memory needs no clearing.
// A result waits in the output register; the next sample is taken meanwhile and
// stalls only when its own result finds that register still full.

module sliding_window_maximum (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    output logic                              s_axis_tready,
    input  wire logic [swm_pkg::SAMPLE_W-1:0] s_axis_tdata,  // [31:0] sample
    input  wire logic                         s_axis_tlast,
    output logic                              m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    output logic [swm_pkg::SAMPLE_W-1:0]      m_axis_tdata,  // [31:0] window_max
    output logic                              m_axis_tlast,
    input  wire logic                         cfg_valid,
    output logic                              cfg_ready,
    input  wire logic [swm_pkg::CFG_W-1:0]    cfg_data       // [6:0] window_size
);

    swm_pkg::swm_cmd_t    cmd;
    swm_pkg::swm_status_t status;

    assign cfg_ready = 1'b1;

    swm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    swm_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_sample (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_max   (m_axis_tdata),
        .out_last  (m_axis_tlast)
    );

endmodule

`default_nettype wire

[src/swm_checker.sv]
`timescale 1ns / 1ps
`default_nettype none

`include "sliding_window_maximum_macros.svh"

module swm_checker (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         s_axis_tvalid,
    input  wire logic                         s_axis_tready,
    input  wire logic [swm_pkg::SAMPLE_W-1:0] s_axis_tdata,
    input  wire logic                         s_axis_tlast,
    input  wire logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    input  wire logic [swm_pkg::SAMPLE_W-1:0] m_axis_tdata,
    input  wire logic                         m_axis_tlast,
    input  wire logic                         cfg_valid,
    input  wire logic                         cfg_ready,
    input  wire logic [swm_pkg::CFG_W-1:0]    cfg_data
);

    // stalled result holds
    `SWM_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))

    // one sample in work at a time
    `SWM_ASSERT_NEXT(a_busy_after_accept, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // a new result only comes out of work on a sample
    `SWM_ASSERT_NOW(a_result_from_work, $rose(m_axis_tvalid), !$past(s_axis_tready))

endmodule

bind sliding_window_maximum swm_checker u_swm_checker (.*);

`default_nettype wire

[sim/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;

    localparam int DRAIN_CYCLES   = 300;
    localparam int HOLD_CYCLES    = 1500;
    localparam int WATCHDOG_LIMIT = 6000;

    typedef struct packed {
        logic [swm_pkg::SAMPLE_W-1:0] max_val;
        logic                         last_flag;
    } window_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         s_axis_tvalid = 1'b0;
    logic                         s_axis_tready;
    logic [swm_pkg::SAMPLE_W-1:0] s_axis_tdata = '0;
    logic                         s_axis_tlast = 1'b0;
    logic                         m_axis_tvalid;
    logic                         m_axis_tready = 1'b0;
    logic [swm_pkg::SAMPLE_W-1:0] m_axis_tdata;
    logic                         m_axis_tlast;
    logic                         cfg_valid = 1'b0;
    logic                         cfg_ready;
    logic [swm_pkg::CFG_W-1:0]    cfg_data = '0;

    int src_idle_pct  = 0;
    int sink_idle_pct = 0;
    int err_count     = 0;
    int idle_cycles   = 0;
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    // model of the max filter
    logic [swm_pkg::SAMPLE_W-1:0] mq_val [swm_pkg::WINDOW_MAX];
    logic [swm_pkg::POS_W-1:0]    mq_pos [swm_pkg::WINDOW_MAX];
    logic [swm_pkg::QIDX_W-1:0]   mq_head  = '0;
    int                           mq_count = 0;
    logic [swm_pkg::POS_W-1:0]    run_pos  = '0;
    int                           run_seen = 0;
    logic [swm_pkg::CFG_W-1:0]    window_reg = swm_pkg::CFG_W'(1);

    window_result_t pending_maxima[$];

    sliding_window_maximum uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int eff_window(input logic [swm_pkg::CFG_W-1:0] v);
        if (v == 0)
            return 1;
        if (v > swm_pkg::WINDOW_MAX)
            return swm_pkg::WINDOW_MAX;
        return int'(v);
    endfunction

    function automatic bit predict_window_max(input logic [swm_pkg::SAMPLE_W-1:0] smp,
                                              input logic lst,
                                              output window_result_t res);
        int                         w;
        logic [swm_pkg::POS_W-1:0]  age;
        logic [swm_pkg::QIDX_W-1:0] tail;
        bit                         produced;
        w = eff_window(window_reg);
        produced = 1'b0;
        res = '0;
        // expire old entries at the head
        while (mq_count > 0)
        begin
            age = run_pos - mq_pos[mq_head];
            if (age < w)
                break;
            mq_head++;
            mq_count--;
        end
        // strictly smaller entries leave from the tail; equal ones stay
        while (mq_count > 0)
        begin
            tail = mq_head + swm_pkg::QIDX_W'(mq_count - 1);
            if (!($signed(mq_val[tail]) < $signed(smp)))
                break;
            mq_count--;
        end
        if (mq_count < swm_pkg::WINDOW_MAX)
        begin
            tail = mq_head + swm_pkg::QIDX_W'(mq_count);
            mq_val[tail] = smp;
            mq_pos[tail] = run_pos;
            mq_count++;
        end
        run_pos++;
        if (run_seen > w)
            run_seen = w;
        if (run_seen < w)
            run_seen++;
        if (run_seen == w)
        begin
            res.max_val = mq_val[mq_head];
            res.last_flag = lst;
            produced = 1'b1;
        end
        if (lst)
        begin
            mq_head = '0;
            mq_count = 0;
            run_pos = '0;
            run_seen = 0;
        end
        return produced;
    endfunction

    function automatic logic [swm_pkg::SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(9))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2, 3: return 32'($urandom_range(7)) - 32'd4;
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [swm_pkg::CFG_W-1:0] pick_window();
        case ($urandom_range(39))
            0: return swm_pkg::CFG_W'(0);
            1: return swm_pkg::CFG_W'(swm_pkg::WINDOW_MAX);
            2: return swm_pkg::CFG_W'(127);
            3: return swm_pkg::CFG_W'($urandom_range(swm_pkg::WINDOW_MAX + 1, 126));
            4, 5, 6, 7: return swm_pkg::CFG_W'($urandom_range(9, 32));
            default: return swm_pkg::CFG_W'($urandom_range(1, 8));
        endcase
    endfunction

    // called and returns at a falling edge; tvalid stays high after the transfer
    task automatic send_sample(input logic [swm_pkg::SAMPLE_W-1:0] smp, input logic lst);
        window_result_t res;
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= smp;
        s_axis_tlast  <= lst;
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (predict_window_max(smp, lst, res))
            pending_maxima.insert(pending_maxima.size(), res);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        s_axis_tvalid <= 1'b0;
        while (pending_maxima.size() != 0)
            @(negedge clk);
        // a sample without a result may still be in flight
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_window(input logic [swm_pkg::CFG_W-1:0] v);
        wait_for_drain();
        cfg_valid <= 1'b1;
        cfg_data  <= v;
        do
            @(posedge clk);
        while (!cfg_ready);
        window_reg = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
    end

    always @(posedge clk)
    begin
        window_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_maxima.size() == 0)
            begin
                $error("unexpected result: window_max %0d last_result %0b",
                       $signed(m_axis_tdata), m_axis_tlast);
                err_count++;
            end
            else
            begin
                want = pending_maxima[0];
                pending_maxima.delete(0);
                if (m_axis_tdata !== want.max_val)
                begin
                    $error("window_max: expected %0d, actual %0d",
                           $signed(want.max_val), $signed(m_axis_tdata));
                    err_count++;
                end
                if (m_axis_tlast !== want.last_flag)
                begin
                    $error("last_result: expected %0b, actual %0b", want.last_flag, m_axis_tlast);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // window of 1 straight out of reset, sample extremes
    task automatic test_reset_window();
        send_sample(32'h8000_0000, 1'b0);
        send_sample(32'h7fff_ffff, 1'b0);
        send_sample(32'hffff_ffff, 1'b0);
        send_sample(32'h0000_0000, 1'b1);
    endtask

    task automatic test_equal_and_order();
        write_window(swm_pkg::CFG_W'(3));
        send_sample(32'd5, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd5, 1'b0);
        send_sample(32'd9, 1'b0);
        send_sample(32'd7, 1'b0);
        send_sample(32'd3, 1'b0);
        send_sample(32'd1, 1'b1);
    endtask

    task automatic test_short_run();
        write_window(swm_pkg::CFG_W'(8));
        send_sample(32'd1, 1'b0);
        send_sample(32'd2, 1'b0);
        send_sample(32'd3, 1'b1);
    endtask

    task automatic test_zero_window();
        write_window(swm_pkg::CFG_W'(0));
        send_sample(-32'sd7, 1'b0);
        send_sample(32'd12, 1'b1);
    endtask

    task automatic test_window_change();
        write_window(swm_pkg::CFG_W'(5));
        send_sample(32'd10, 1'b0);
        send_sample(32'd3, 1'b0);
        send_sample(32'd2, 1'b0);
        send_sample(32'd1, 1'b0);
        write_window(swm_pkg::CFG_W'(2));
        send_sample(32'd0, 1'b0);
        send_sample(32'd4, 1'b0);
        send_sample(32'd0, 1'b1);
    endtask

    // output held off long enough that the block backs up into its input
    task automatic test_backpressure();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        write_window(swm_pkg::CFG_W'(2));
        hold_requests++;
        for (int i = 0; i < 40; i++)
            send_sample(pick_sample(), 1'b0);
        send_sample(pick_sample(), 1'b1);
    endtask

    task automatic test_sender_pause();
        write_window(swm_pkg::CFG_W'(4));
        for (int i = 0; i < 10; i++)
            send_sample(pick_sample(), 1'b0);
        wait_for_drain();
        for (int i = 0; i < 10; i++)
            send_sample(pick_sample(), i == 9);
    endtask

    task automatic test_random_runs(input int src_pct, input int sink_pct, input int budget);
        int                        sent;
        int                        len;
        int                        w;
        logic [swm_pkg::CFG_W-1:0] wv;
        src_idle_pct = src_pct;
        sink_idle_pct = sink_pct;
        sent = 0;
        while (sent < budget)
        begin
            wv = pick_window();
            write_window(wv);
            w = eff_window(wv);
            if (w > 1 && $urandom_range(4) == 0)
                len = $urandom_range(1, w - 1);
            else
                len = w + $urandom_range(0, 12);
            for (int i = 0; i < len; i++)
            begin
                if (i > 0 && $urandom_range(39) == 0)
                    write_window(pick_window());
                send_sample(pick_sample(), i == len - 1);
            end
            sent += len;
        end
    endtask

    // one run long enough to wrap the position counter
    task automatic test_position_wrap();
        src_idle_pct = 0;
        sink_idle_pct = 0;
        write_window(swm_pkg::CFG_W'(5));
        for (int i = 0; i < 4 * swm_pkg::WINDOW_MAX + 2; i++)
            send_sample(pick_sample(), i == 4 * swm_pkg::WINDOW_MAX + 1);
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        src_idle_pct = 37;
        sink_idle_pct = 57;
        test_reset_window();
        test_equal_and_order();
        test_short_run();
        test_zero_window();
        test_window_change();
        test_random_runs(37, 57, 40);
        test_random_runs(57, 37, 40);
        test_backpressure();
        test_sender_pause();
        test_position_wrap();
        test_random_runs(0, 0, 20);
        wait_for_drain();
        if (err_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
